// ===== rtl/assert_macros.svh =====
// Assertion macros included by the RTL queue module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CED_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CED_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define CED_ASSERT(lbl, clk, rst_n, prop, msg)
`define CED_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/ced_pkg.sv =====
// Types, codes and kernel tables of the compass edge detector
package ced_pkg;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;
  localparam int KSET_REG_W   = 2;
  localparam int PIX_W        = 8;
  localparam int MAG_W        = 12;
  localparam int DIR_W        = 2;
  localparam int RESP_W       = 13;
  localparam int NUM_SETS     = 3;
  localparam int NUM_DIRS     = 4;
  localparam int NUM_TAPS     = 9;
  localparam int QUEUE_DEPTH  = 2;
  localparam int APB_ADDR_W   = 4;
  localparam int APB_DATA_W   = 32;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_KERNEL_SET   = 2'd2
  } reg_index_e;

  typedef enum logic [KSET_REG_W-1:0] {
    KSET_PREWITT = 2'd0,
    KSET_SOBEL   = 2'd1,
    KSET_KIRSCH  = 2'd2
  } kernel_set_e;

  typedef struct packed {
    logic [WIDTH_REG_W-1:0]  image_width;
    logic [HEIGHT_REG_W-1:0] image_height;
    logic [KSET_REG_W-1:0]   kernel_set;
  } cfg_t;

  typedef struct packed {
    logic [NUM_TAPS-1:0][PIX_W-1:0] pix;
    logic                           last;
  } win_item_t;

  typedef logic signed [3:0] coef_t;

  // [set][direction][row*3+col]
  localparam coef_t KERNELS [NUM_SETS][NUM_DIRS][NUM_TAPS] = '{
    '{
      '{-4'sd1,  4'sd0,  4'sd1, -4'sd1,  4'sd0,  4'sd1, -4'sd1,  4'sd0,  4'sd1},
      '{-4'sd1, -4'sd1, -4'sd1,  4'sd0,  4'sd0,  4'sd0,  4'sd1,  4'sd1,  4'sd1},
      '{ 4'sd0,  4'sd1,  4'sd1, -4'sd1,  4'sd0,  4'sd1, -4'sd1, -4'sd1,  4'sd0},
      '{ 4'sd1,  4'sd1,  4'sd0,  4'sd1,  4'sd0, -4'sd1,  4'sd0, -4'sd1, -4'sd1}
    },
    '{
      '{-4'sd1,  4'sd0,  4'sd1, -4'sd2,  4'sd0,  4'sd2, -4'sd1,  4'sd0,  4'sd1},
      '{-4'sd1, -4'sd2, -4'sd1,  4'sd0,  4'sd0,  4'sd0,  4'sd1,  4'sd2,  4'sd1},
      '{ 4'sd0,  4'sd1,  4'sd2, -4'sd1,  4'sd0,  4'sd1, -4'sd2, -4'sd1,  4'sd0},
      '{ 4'sd2,  4'sd1,  4'sd0,  4'sd1,  4'sd0, -4'sd1,  4'sd0, -4'sd1, -4'sd2}
    },
    '{
      '{-4'sd3, -4'sd3,  4'sd5, -4'sd3,  4'sd0,  4'sd5, -4'sd3, -4'sd3,  4'sd5},
      '{-4'sd3, -4'sd3, -4'sd3,  4'sd5,  4'sd0, -4'sd3,  4'sd5,  4'sd5, -4'sd3},
      '{-4'sd3,  4'sd5,  4'sd5, -4'sd3,  4'sd0,  4'sd5, -4'sd3, -4'sd3, -4'sd3},
      '{ 4'sd5,  4'sd5, -4'sd3,  4'sd5,  4'sd0, -4'sd3, -4'sd3, -4'sd3, -4'sd3}
    }
  };

endpackage

// ===== rtl/ced_pixel_if.sv =====
// Pixel input channel
interface ced_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [ced_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

// ===== rtl/ced_result_if.sv =====
// Edge result output channel
interface ced_result_if;
  logic                      valid;
  logic                      ready;
  logic [ced_pkg::MAG_W-1:0] magnitude;
  logic [ced_pkg::DIR_W-1:0] direction;
  logic                      last_of_frame;

  modport source (output valid, output magnitude, output direction, output last_of_frame,
                  input ready);
  modport sink (input valid, input magnitude, input direction, input last_of_frame,
                output ready);
endinterface

// ===== rtl/compass_edge_max_direction_3x3_core.sv =====
// Compass edge detector top level: register port, front end, queue and back end
// Throughput: one pixel per clock while the queue is not full; border pixels transfer
// in but give no result. A result passes the line store read, queue stage, kernel
// stage and output register, and is held there while the output stalls.
// Reset: asynchronous, active low; clears position, valids and registers to defaults.
// Line stores are not cleared; unwritten entries only reach border pixels (no result).
module compass_edge_max_direction_3x3_core #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ced_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [ced_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [ced_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  ced_pixel_if.sink                          pix_i,
  ced_result_if.source                       res_o
);

  ced_pkg::cfg_t      cfg_q;
  ced_pkg::win_item_t push_item;
  ced_pkg::win_item_t pop_item;
  logic               wr_en;
  logic               restart;
  logic               push;
  logic               pop;
  logic               full;
  logic               empty;
  logic [1:0]         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    restart = 1'b0;
    prdata  = '0;
    case (reg_idx)
      ced_pkg::REG_IMAGE_WIDTH: begin
        restart = wr_en;
        prdata  = ced_pkg::APB_DATA_W'(cfg_q.image_width);
      end
      ced_pkg::REG_IMAGE_HEIGHT: begin
        restart = wr_en;
        prdata  = ced_pkg::APB_DATA_W'(cfg_q.image_height);
      end
      ced_pkg::REG_KERNEL_SET: begin
        restart = wr_en;
        prdata  = ced_pkg::APB_DATA_W'(cfg_q.kernel_set);
      end
      default: begin
        restart = 1'b0;
        prdata  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= ced_pkg::WIDTH_RESET;
      cfg_q.image_height <= ced_pkg::HEIGHT_RESET;
      cfg_q.kernel_set   <= ced_pkg::KSET_PREWITT;
    end else if (wr_en) begin
      case (reg_idx)
        ced_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[ced_pkg::WIDTH_REG_W-1:0];
        ced_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[ced_pkg::HEIGHT_REG_W-1:0];
        ced_pkg::REG_KERNEL_SET:   cfg_q.kernel_set   <= pwdata[ced_pkg::KSET_REG_W-1:0];
        default: ;
      endcase
    end
  end

  ced_front #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .restart_i(restart),
    .pix_i    (pix_i),
    .push_o   (push),
    .item_o   (push_item),
    .full_i   (full)
  );

  ced_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .item_o (pop_item)
  );

  ced_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .empty_i(empty),
    .item_i (pop_item),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule

// ===== rtl/ced_front.sv =====
// Front end: frame position, line stores, window and interior classification
module ced_front #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ced_pkg::cfg_t      cfg_i,
  input  logic               restart_i,
  ced_pixel_if.sink          pix_i,
  output logic               push_o,
  output ced_pkg::win_item_t item_o,
  input  logic               full_i
);

  localparam int COL_W = $clog2(MAX_LINE_WIDTH);
  localparam int EW_W  = $clog2(MAX_LINE_WIDTH + 1);
  localparam int CW    = (EW_W > ced_pkg::WIDTH_REG_W) ? EW_W : ced_pkg::WIDTH_REG_W;
  localparam int PW    = ced_pkg::PIX_W;
  localparam int HW    = ced_pkg::HEIGHT_REG_W;

  logic [PW-1:0] line_upper_q [MAX_LINE_WIDTH];
  logic [PW-1:0] line_middle_q [MAX_LINE_WIDTH];

  logic [COL_W-1:0] col_q, col_d;
  logic [HW-1:0]    row_q, row_d;
  logic             s1_valid_q;
  logic [PW-1:0]    s1_pix_q;
  logic [COL_W-1:0] s1_addr_q;
  logic             s1_produce_q;
  logic             s1_last_q;
  logic [PW-1:0]    top_q;
  logic [PW-1:0]    mid_q;
  logic [5:0][PW-1:0] win_q;

  logic [CW-1:0]    w_ext;
  logic [CW-1:0]    w_clamp;
  logic [EW_W-1:0]  w_m1;
  logic [HW-1:0]    h_m1;
  logic             col_end;
  logic             row_end;
  logic             accept;
  logic             s1_adv;

  always_comb begin
    w_ext = CW'(cfg_i.image_width);
    if (w_ext < CW'(3)) begin
      w_clamp = CW'(3);
    end else if (w_ext > CW'(MAX_LINE_WIDTH)) begin
      w_clamp = CW'(MAX_LINE_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
    w_m1 = EW_W'(w_clamp - CW'(1));
    h_m1 = (cfg_i.image_height < HW'(3)) ? HW'(2) : cfg_i.image_height - HW'(1);
  end

  assign col_end  = (EW_W'(col_q) == w_m1);
  assign row_end  = (row_q == h_m1);
  assign s1_adv   = s1_valid_q && (!s1_produce_q || !full_i);
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign accept   = pix_i.valid && pix_i.ready;
  assign push_o   = s1_valid_q && s1_produce_q && !full_i;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + HW'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      win_q      <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        win_q <= {s1_pix_q, mid_q, top_q, win_q[5], win_q[4], win_q[3]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_q        <= line_upper_q[col_q];
      mid_q        <= line_middle_q[col_q];
      s1_pix_q     <= pix_i.pixel;
      s1_addr_q    <= col_q;
      s1_produce_q <= (row_q >= HW'(2)) && (col_q >= COL_W'(2));
      s1_last_q    <= col_end && row_end;
    end
    if (s1_adv) begin
      line_upper_q[s1_addr_q]  <= mid_q;
      line_middle_q[s1_addr_q] <= s1_pix_q;
    end
  end

  assign item_o.pix  = {s1_pix_q, win_q[5], win_q[2], mid_q, win_q[4], win_q[1],
                        top_q, win_q[3], win_q[0]};
  assign item_o.last = s1_last_q;

endmodule

// ===== rtl/ced_queue.sv =====
// Short queue of interior windows between front and back
module ced_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ced_pkg::win_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output ced_pkg::win_item_t item_o
);

  `include "assert_macros.svh"

  localparam int DEPTH = ced_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ced_pkg::win_item_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `CED_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(DEPTH), "queue overfilled")
  `CED_ASSERT(a_pop_nonempty, clk_i, rst_ni, pop_i |-> count_q != '0, "pop from empty queue")
  `CED_ASSERT(a_push_room, clk_i, rst_ni, push_i |-> (!full_o || pop_i), "push into full queue")
  `CED_ASSERT_NEXT(a_count_up, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + CNT_W'(1), "count missed push")

endmodule

// ===== rtl/ced_back.sv =====
// Back end: four directional kernels, maximum selection and output register
module ced_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ced_pkg::cfg_t      cfg_i,
  input  logic               empty_i,
  input  ced_pkg::win_item_t item_i,
  output logic               pop_o,
  ced_result_if.source       res_o
);

  localparam int RW = ced_pkg::RESP_W;
  localparam int ND = ced_pkg::NUM_DIRS;
  localparam int NS = ced_pkg::NUM_SETS;
  localparam int NT = ced_pkg::NUM_TAPS;
  localparam int PW = ced_pkg::PIX_W;

  logic signed [RW-1:0] sums [NS][ND];
  logic signed [RW-1:0] resp_sel [ND];
  logic signed [RW-1:0] resp_a_q [ND];
  logic                 last_a_q;
  logic                 a_valid_q;
  logic                 a_en;
  logic                 out_en;
  logic [RW-1:0]        abs_v [ND];
  logic [RW-1:0]        best;
  logic [ced_pkg::DIR_W-1:0] best_dir;
  logic [ced_pkg::MAG_W-1:0] mag_q;
  logic [ced_pkg::DIR_W-1:0] dir_q;
  logic                 last_q;
  logic                 out_valid_q;

  assign out_en = !out_valid_q || res_o.ready;
  assign a_en   = !a_valid_q || out_en;
  assign pop_o  = !empty_i && a_en;

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      for (int d = 0; d < ND; d++) begin
        sums[s][d] = '0;
        for (int k = 0; k < NT; k++) begin
          sums[s][d] = sums[s][d] + RW'($signed({{(RW - PW){1'b0}}, item_i.pix[k]})
                       * RW'(ced_pkg::KERNELS[s][d][k]));
        end
      end
    end
  end

  always_comb begin
    for (int d = 0; d < ND; d++) begin
      case (cfg_i.kernel_set)
        ced_pkg::KSET_SOBEL:  resp_sel[d] = sums[1][d];
        ced_pkg::KSET_KIRSCH: resp_sel[d] = sums[2][d];
        default:              resp_sel[d] = sums[0][d];
      endcase
    end
  end

  always_comb begin
    best     = '0;
    best_dir = '0;
    for (int d = 0; d < ND; d++) begin
      abs_v[d] = resp_a_q[d][RW-1] ? RW'(-resp_a_q[d]) : RW'(resp_a_q[d]);
      if (abs_v[d] > best) begin
        best     = abs_v[d];
        best_dir = ced_pkg::DIR_W'(d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid_q <= !empty_i;
      end
      if (out_en) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      resp_a_q <= resp_sel;
      last_a_q <= item_i.last;
    end
    if (out_en && a_valid_q) begin
      mag_q  <= ced_pkg::MAG_W'(best);
      dir_q  <= best_dir;
      last_q <= last_a_q;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.magnitude     = mag_q;
  assign res_o.direction     = dir_q;
  assign res_o.last_of_frame = last_q;

endmodule
